/* hdl/block_average_downscaler_assert.svh */
// Assertion macros for the port-level checker
`ifndef BLOCK_AVERAGE_DOWNSCALER_ASSERT_SVH
`define BLOCK_AVERAGE_DOWNSCALER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define BAD_ASSERT_IMP(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication outside reset
`define BAD_ASSERT_NXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* hdl/bad_pkg.sv */
// ----------------------------------------------------------------------------
// bad_pkg
// Shared types and constants of the block average downscaler.
// ----------------------------------------------------------------------------
package bad_pkg;
  localparam int MaxDstWidth = 1024;
  localparam int MaxSrcDim   = 4096;
  localparam int SumWidth    = 18;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 13;

  localparam logic [CfgIdxW-1:0] RegSrcWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSrcHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDstWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDstHeight = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRowScale  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegColScale  = 3'd5;

  // Front to back command: one accumulate step, maybe closing a block
  typedef struct packed {
    logic [11:0] col;      // accumulator index (out column)
    logic        first;    // first row of band: overwrite
    logic        emit;     // last pixel of block
    logic        fend;     // last output pixel of the frame
    logic [12:0] rows;     // band height
    logic [12:0] cols;     // block width
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
  } cmd_t;
endpackage

/* hdl/bad_ram.sv */
// ----------------------------------------------------------------------------
// bad_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bad_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/bad_div.sv */
// ----------------------------------------------------------------------------
// bad_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bad_div #(
  parameter int NumW = 18,
  parameter int DenW = 26
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [7:0]      quo_o
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] num_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0]   trial;

  assign trial = {rem_q[DenW-1:0], num_q[NumW-1]};

  // Shift one numerator bit in per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NumW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = (quo_q > NumW'(255)) ? 8'd255 : quo_q[7:0];
endmodule

/* hdl/bad_front.sv */
// ----------------------------------------------------------------------------
// bad_front
// Tracks raster position and band/block bounds; classifies each pixel.
// ----------------------------------------------------------------------------
module bad_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [12:0]             sw_i,
  input  logic [12:0]             sh_i,
  input  logic [12:0]             dw_i,
  input  logic [12:0]             dh_i,
  input  logic [12:0]             rs_i,
  input  logic [12:0]             cs_i,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              c0_i,
  input  logic [7:0]              c1_i,
  input  logic [7:0]              c2_i,
  output logic                    cmd_valid_o,
  output bad_pkg::cmd_t           cmd_o,
  input  logic                    q_full_i
);
  logic [12:0] row_q, row_d, col_q, col_d, orow_q, orow_d, ocol_q, ocol_d;
  logic [12:0] btop_q, btop_d, bbot_q, bbot_d, bleft_q, bleft_d, bright_q, bright_d;
  // Running (k+1)*scale values, one add per span instead of a multiply
  logic [25:0] racc_q, racc_d, cacc_q, cacc_d;
  logic        acc_en, hit, at_right, at_bottom;

  function automatic logic [12:0] span_end(input logic [25:0] prod, input logic [12:0] start,
                                           input logic [12:0] dim);
    logic [25:0] e;
    logic [17:0] em;
    e  = (prod + 26'd128) >> 8;
    em = (e[17:0] == '0) ? 18'd0 : e[17:0] - 18'd1;
    if (em > {5'd0, dim - 13'd1}) em = {5'd0, dim - 13'd1};
    if (em < {5'd0, start}) em = {5'd0, start};
    return em[12:0];
  endfunction

  // Hold input while the queue is full or the frame restarts on new registers
  assign in_stall = q_full_i || cfg_we_i;
  assign acc_en   = in_valid && !in_stall;
  assign hit      = (orow_q < dh_i) && (ocol_q < dw_i) && (row_q >= btop_q) &&
                    (row_q <= bbot_q) && (col_q >= bleft_q) && (col_q <= bright_q);
  assign at_right  = (col_q == bright_q);
  assign at_bottom = (row_q == bbot_q);

  // Classify current pixel into a back-end command
  always_comb begin
    cmd_valid_o = acc_en && hit;
    cmd_o.col   = ocol_q[11:0];
    cmd_o.first = (row_q == btop_q);
    cmd_o.emit  = at_right && at_bottom;
    cmd_o.fend  = (orow_q == dh_i - 13'd1) && (ocol_q == dw_i - 13'd1);
    cmd_o.rows  = bbot_q - btop_q + 13'd1;
    cmd_o.cols  = bright_q - bleft_q + 13'd1;
    cmd_o.c0    = c0_i;
    cmd_o.c1    = c1_i;
    cmd_o.c2    = c2_i;
  end

  // Advance position, band and block state
  always_comb begin
    row_d = row_q; col_d = col_q; orow_d = orow_q; ocol_d = ocol_q;
    btop_d = btop_q; bbot_d = bbot_q; bleft_d = bleft_q; bright_d = bright_q;
    racc_d = racc_q; cacc_d = cacc_q;
    if (cfg_we_i) begin
      row_d = '0; col_d = '0; orow_d = '0; ocol_d = '0; btop_d = '0; bleft_d = '0;
      racc_d = {13'd0, rs_i}; cacc_d = {13'd0, cs_i};
      bbot_d = span_end({13'd0, rs_i}, 13'd0, sh_i);
      bright_d = span_end({13'd0, cs_i}, 13'd0, sw_i);
    end else if (acc_en) begin
      if (hit && at_right) begin
        ocol_d   = ocol_q + 13'd1;
        bleft_d  = bright_q + 13'd1;
        cacc_d   = cacc_q + {13'd0, cs_i};
        bright_d = span_end(cacc_q + {13'd0, cs_i}, bright_q + 13'd1, sw_i);
      end
      if (col_q + 13'd1 >= sw_i) begin
        col_d = '0; ocol_d = '0; bleft_d = '0;
        cacc_d = {13'd0, cs_i};
        bright_d = span_end({13'd0, cs_i}, 13'd0, sw_i);
        if (row_q + 13'd1 >= sh_i) begin
          row_d = '0; orow_d = '0; btop_d = '0;
          racc_d = {13'd0, rs_i};
          bbot_d = span_end({13'd0, rs_i}, 13'd0, sh_i);
        end else begin
          row_d = row_q + 13'd1;
          if (orow_q < dh_i && at_bottom) begin
            orow_d = orow_q + 13'd1;
            btop_d = bbot_q + 13'd1;
            racc_d = racc_q + {13'd0, rs_i};
            bbot_d = span_end(racc_q + {13'd0, rs_i}, bbot_q + 13'd1, sh_i);
          end
        end
      end else begin
        col_d = col_q + 13'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; col_q <= '0; orow_q <= '0; ocol_q <= '0;
      btop_q <= '0; bleft_q <= '0; bbot_q <= 13'd1; bright_q <= 13'd1;
      racc_q <= 26'd512; cacc_q <= 26'd512;
    end else begin
      row_q <= row_d; col_q <= col_d; orow_q <= orow_d; ocol_q <= ocol_d;
      btop_q <= btop_d; bleft_q <= bleft_d; bbot_q <= bbot_d; bright_q <= bright_d;
      racc_q <= racc_d; cacc_q <= cacc_d;
    end
  end
endmodule

/* hdl/bad_back.sv */
// ----------------------------------------------------------------------------
// bad_back
// Column accumulators in RAM, block averaging through one divider per channel.
// ----------------------------------------------------------------------------
module bad_back #(
  parameter int MaxDstWidth = bad_pkg::MaxDstWidth,
  parameter int SumWidth    = bad_pkg::SumWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  bad_pkg::cmd_t cmd_i,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_c0_o,
  output logic [7:0]    out_c1_o,
  output logic [7:0]    out_c2_o,
  output logic          frame_end_o
);
  localparam int AW = $clog2(MaxDstWidth);
  localparam logic [SumWidth:0] SumMax = {1'b0, {SumWidth{1'b1}}};
  typedef enum logic [2:0] {S_IDLE, S_READ, S_ADD, S_DIV, S_WAIT, S_OUT} state_e;
  state_e state_q;
  logic [SumWidth-1:0] rd [3];
  logic [SumWidth-1:0] sum_q [3];
  logic [SumWidth-1:0] nsum [3];
  logic [7:0] quo [3];
  logic [7:0] px [3];
  logic [2:0] busy;
  logic we, div_go;
  logic [25:0] cnt_q;
  logic [7:0] res_q [3];
  logic fend_q;
  bad_pkg::cmd_t cmd_q;

  assign px[0] = cmd_q.c0;
  assign px[1] = cmd_q.c1;
  assign px[2] = cmd_q.c2;

  // Saturating accumulate or overwrite on the first band row
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [SumWidth:0] s;
      s = cmd_q.first ? {{(SumWidth-7){1'b0}}, px[i]}
                      : {1'b0, rd[i]} + {{(SumWidth-7){1'b0}}, px[i]};
      nsum[i] = (s > SumMax) ? SumMax[SumWidth-1:0] : s[SumWidth-1:0];
    end
  end

  assign we     = (state_q == S_ADD);
  assign div_go = (state_q == S_DIV);

  for (genvar g = 0; g < 3; g++) begin : g_ch
    bad_ram #(.Width(SumWidth), .Depth(MaxDstWidth)) u_ram (
      .clk_i, .we_i(we), .waddr_i(cmd_q.col[AW-1:0]), .wdata_i(nsum[g]),
      .raddr_i(cmd_q.col[AW-1:0]), .rdata_o(rd[g]));
    bad_div #(.NumW(SumWidth), .DenW(26)) u_div (
      .clk_i, .rst_ni, .start_i(div_go), .num_i(sum_q[g]), .den_i(cnt_q),
      .busy_o(busy[g]), .quo_o(quo[g]));
  end

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid = (state_q == S_OUT);
  assign out_c0_o  = res_q[0];
  assign out_c1_o  = res_q[1];
  assign out_c2_o  = res_q[2];
  assign frame_end_o = fend_q;

  // Sequence: read, write back, divide if the block closes, present
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (cmd_valid_i) state_q <= S_READ;
        S_READ: state_q <= S_ADD;
        S_ADD: state_q <= cmd_q.emit ? S_DIV : S_IDLE;
        S_DIV: state_q <= S_WAIT;
        S_WAIT: if (busy == 3'b000) state_q <= S_OUT;
        S_OUT: if (!out_stall) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (we) begin
      sum_q <= nsum;
      cnt_q <= cmd_q.rows * cmd_q.cols;
      fend_q <= cmd_q.fend;
    end
    if (state_q == S_WAIT && busy == 3'b000) res_q <= quo;
  end
endmodule

/* hdl/bad_fifo.sv */
// ----------------------------------------------------------------------------
// bad_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module bad_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bad_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bad_pkg::cmd_t data_o
);
  localparam int AW = $clog2(Depth);
  bad_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];

  // Advance pointers on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
endmodule

/* hdl/block_average_downscaler.sv */
// Flow: each pixel command passes the back end's read and write-back states; a block-closing
// one then also passes the divide, wait and present states before the back end takes another
// command (serial divider, one quotient bit a cycle); a 4-entry queue buffers. Input stalls in
// the cycle after each configuration write.
// Reset: all registers reset to 640x480 -> 320x240, scale 2.0; sums undefined
// until a band's first row writes them.
// ----------------------------------------------------------------------------
// block_average_downscaler
// Area-average image downscaler, top level.
// ----------------------------------------------------------------------------
module block_average_downscaler #(
  parameter int MaxDstWidth = bad_pkg::MaxDstWidth,
  parameter int SumWidth    = bad_pkg::SumWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_c0_i,
  input  logic [7:0]  in_c1_i,
  input  logic [7:0]  in_c2_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_c0_o,
  output logic [7:0]  out_c1_o,
  output logic [7:0]  out_c2_o,
  output logic        frame_end_o
);
  logic [12:0] sw_q, sh_q, dw_q, dh_q, rs_q, cs_q;
  logic [12:0] sw, sh, dw, dh;
  logic cfg_we, push, full, pop, qvalid;
  bad_pkg::cmd_t cmd_in, cmd_out;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && (cfg_index_i <= bad_pkg::RegColScale);

  // Clamp registers to legal ranges
  assign sw = (sw_q == '0) ? 13'd1 : (sw_q > 13'd4096 ? 13'd4096 : sw_q);
  assign sh = (sh_q == '0) ? 13'd1 : (sh_q > 13'd4096 ? 13'd4096 : sh_q);
  assign dw = (dw_q == '0) ? 13'd1 : (dw_q > 13'(MaxDstWidth) ? 13'(MaxDstWidth) : dw_q);
  assign dh = (dh_q == '0) ? 13'd1 : (dh_q > 13'd4096 ? 13'd4096 : dh_q);

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 13'd640; sh_q <= 13'd480; dw_q <= 13'd320; dh_q <= 13'd240;
      rs_q <= 13'd512; cs_q <= 13'd512;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        bad_pkg::RegSrcWidth:  sw_q <= cfg_data_i;
        bad_pkg::RegSrcHeight: sh_q <= cfg_data_i;
        bad_pkg::RegDstWidth:  dw_q <= {2'b00, cfg_data_i[10:0]};
        bad_pkg::RegDstHeight: dh_q <= cfg_data_i;
        bad_pkg::RegRowScale:  rs_q <= cfg_data_i;
        bad_pkg::RegColScale:  cs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front reads the new values in the cycle after the write
  logic cfg_we_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_we_q <= 1'b0;
    else cfg_we_q <= cfg_we;
  end

  bad_front u_front (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we_q), .sw_i(sw), .sh_i(sh), .dw_i(dw), .dh_i(dh),
    .rs_i(rs_q), .cs_i(cs_q), .in_valid, .in_stall, .c0_i(in_c0_i), .c1_i(in_c1_i),
    .c2_i(in_c2_i), .cmd_valid_o(push), .cmd_o(cmd_in), .q_full_i(full));

  bad_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(cmd_in), .full_o(full), .pop_i(pop),
    .valid_o(qvalid), .data_o(cmd_out));

  bad_back #(.MaxDstWidth(MaxDstWidth), .SumWidth(SumWidth)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(qvalid), .cmd_pop_o(pop), .cmd_i(cmd_out),
    .out_valid, .out_stall, .out_c0_o, .out_c1_o, .out_c2_o, .frame_end_o);
endmodule

/* hdl/bad_checker.sv */
// ----------------------------------------------------------------------------
// bad_checker
// Port-level checks of the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_average_downscaler_assert.svh"
module bad_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_c0_o,
  input logic       frame_end_o
);
  `BAD_ASSERT_IMP(a_cfg_rdy, clk_i, rst_ni, 1'b1, cfg_ready)
  `BAD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && out_stall, out_valid)
  `BAD_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid && out_stall, $stable(out_c0_o) && $stable(frame_end_o))
  `BAD_ASSERT_NXT(a_out_gap, clk_i, rst_ni, out_valid && !out_stall, !out_valid)
endmodule

bind block_average_downscaler bad_checker u_checker (
  .clk_i, .rst_ni, .cfg_ready, .out_valid, .out_stall, .out_c0_o, .frame_end_o);

/* test/block_average_downscaler_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_average_downscaler_test
// Drives pixel frames through the downscaler under several scale settings,
// predicts every block average and frame end, and checks each output transfer
// in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module block_average_downscaler_test;

  localparam int CycleLimit = 3000000;
  localparam int DrainCycles = 60;

  typedef struct {
    bit [7:0] c0;
    bit [7:0] c1;
    bit [7:0] c2;
    bit       fend;
  } pixel_avg_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_c0_i;
  logic [7:0]  in_c1_i;
  logic [7:0]  in_c2_i;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_c0_o;
  logic [7:0]  out_c1_o;
  logic [7:0]  out_c2_o;
  logic        frame_end_o;

  block_average_downscaler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_c0_i     (in_c0_i),
    .in_c1_i     (in_c1_i),
    .in_c2_i     (in_c2_i),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_c0_o    (out_c0_o),
    .out_c1_o    (out_c1_o),
    .out_c2_o    (out_c2_o),
    .frame_end_o (frame_end_o)
  );

  // Scaler state mirrored from the block
  bit [12:0] reg_src_w, reg_src_h, reg_dst_w, reg_dst_h, reg_row_scale, reg_col_scale;
  bit [17:0] acc_c0 [bad_pkg::MaxDstWidth];
  bit [17:0] acc_c1 [bad_pkg::MaxDstWidth];
  bit [17:0] acc_c2 [bad_pkg::MaxDstWidth];
  int unsigned row_pos, col_pos, out_row, out_col;
  int unsigned band_top, band_bot, blk_left, blk_right;

  pixel_avg_t pending_averages[$];
  int  errors;
  int  mismatches;
  int  cycles;
  bit  quiet;       // no idling on either side
  int  hold_seq;    // bumped to request a long receiver hold-off

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // End of span k, clamped to the image and never before its start
  function automatic int unsigned span_last(int unsigned k, int unsigned scale,
                                            int unsigned start, int unsigned dim);
    int unsigned e;
    int unsigned last;
    e = ((k + 1) * scale + 128) >> 8;
    last = (e == 0) ? 0 : e - 1;
    if (last > dim - 1) last = dim - 1;
    if (last < start) last = start;
    return last;
  endfunction

  function automatic void restart_row();
    col_pos = 0;
    out_col = 0;
    blk_left = 0;
    blk_right = span_last(0, reg_col_scale, 0, clamp_dim(reg_src_w, bad_pkg::MaxSrcDim));
  endfunction

  function automatic void restart_frame();
    row_pos = 0;
    out_row = 0;
    band_top = 0;
    band_bot = span_last(0, reg_row_scale, 0, clamp_dim(reg_src_h, bad_pkg::MaxSrcDim));
    restart_row();
  endfunction

  function automatic bit [17:0] add_sat(bit [17:0] old, bit [7:0] pix, bit first);
    int unsigned s;
    s = first ? pix : old + pix;
    return (s > 262143) ? 18'h3ffff : s[17:0];
  endfunction

  function automatic bit [7:0] floor_avg(bit [17:0] s, longint unsigned n);
    longint unsigned q;
    q = s / n;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic void apply_register(bit [2:0] idx, bit [12:0] v);
    case (idx)
      bad_pkg::RegSrcWidth:  reg_src_w = v;
      bad_pkg::RegSrcHeight: reg_src_h = v;
      bad_pkg::RegDstWidth:  reg_dst_w = v & 13'h7ff;
      bad_pkg::RegDstHeight: reg_dst_h = v;
      bad_pkg::RegRowScale:  reg_row_scale = v;
      bad_pkg::RegColScale:  reg_col_scale = v;
      default: return;
    endcase
    restart_frame();
  endfunction

  // Accumulate one source pixel; queue an average when it closes a block
  function automatic void predict_pixel(bit [7:0] p0, bit [7:0] p1, bit [7:0] p2);
    int unsigned sw, sh, dw, dh, r, c, k;
    bit first, adv_band;
    longint unsigned n;
    pixel_avg_t a;
    sw = clamp_dim(reg_src_w, bad_pkg::MaxSrcDim);
    sh = clamp_dim(reg_src_h, bad_pkg::MaxSrcDim);
    dw = clamp_dim(reg_dst_w, bad_pkg::MaxDstWidth);
    dh = clamp_dim(reg_dst_h, bad_pkg::MaxSrcDim);
    r = row_pos;
    c = col_pos;
    if (out_row < dh && out_col < dw && r >= band_top && r <= band_bot &&
        c >= blk_left && c <= blk_right) begin
      k = out_col;
      first = (r == band_top);
      acc_c0[k] = add_sat(acc_c0[k], p0, first);
      acc_c1[k] = add_sat(acc_c1[k], p1, first);
      acc_c2[k] = add_sat(acc_c2[k], p2, first);
      if (c == blk_right) begin
        if (r == band_bot) begin
          n = longint'(band_bot - band_top + 1) * longint'(blk_right - blk_left + 1);
          a.c0 = floor_avg(acc_c0[k], n);
          a.c1 = floor_avg(acc_c1[k], n);
          a.c2 = floor_avg(acc_c2[k], n);
          a.fend = (out_row == dh - 1 && k == dw - 1);
          pending_averages.push_back(a);
        end
        out_col = k + 1;
        blk_left = blk_right + 1;
        blk_right = span_last(out_col, reg_col_scale, blk_left, sw);
      end
    end
    if (c + 1 >= sw) begin
      adv_band = (out_row < dh && r == band_bot);
      if (r + 1 >= sh) begin
        restart_frame();
      end else begin
        restart_row();
        row_pos = r + 1;
        if (adv_band) begin
          out_row++;
          band_top = band_bot + 1;
          band_bot = span_last(out_row, reg_row_scale, band_top, sh);
        end
      end
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // Clock and cycle limit
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver stall: random, quiet, or a long hold-off counted here
  int hold_left;
  int hold_seen;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 33);
    end
  end

  // Check each output transfer against the oldest pending average
  always @(negedge clk_i) begin
    pixel_avg_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_averages.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output %0d %0d %0d fend %0d",
                   out_c0_o, out_c1_o, out_c2_o, frame_end_o);
      end else begin
        e = pending_averages.pop_front();
        if (out_c0_o !== e.c0 || out_c1_o !== e.c1 || out_c2_o !== e.c2 ||
            frame_end_o !== e.fend) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d fend %0d, got %0d %0d %0d fend %0d",
                     e.c0, e.c1, e.c2, e.fend,
                     out_c0_o, out_c1_o, out_c2_o, frame_end_o);
        end
      end
    end
  end

  // Send one pixel, idling at random beforehand
  task automatic send_pixel(bit [7:0] p0, bit [7:0] p1, bit [7:0] p2);
    bit taken;
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_c0_i <= p0;
    in_c1_i <= p1;
    in_c2_i <= p2;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end
    predict_pixel(p0, p1, p2);
  endtask

  task automatic send_random(int n);
    repeat (n) send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
    in_valid <= 1'b0;
  endtask

  // Wait until every average has arrived and the pipeline has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(bit [2:0] idx, bit [12:0] v);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready;
      @(posedge clk_i);
    end
    apply_register(idx, v);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(int sw, int sh, int dw, int dh, int rs, int cs);
    drain();
    write_register(bad_pkg::RegSrcWidth, 13'(sw));
    write_register(bad_pkg::RegSrcHeight, 13'(sh));
    write_register(bad_pkg::RegDstWidth, 13'(dw));
    write_register(bad_pkg::RegDstHeight, 13'(dh));
    write_register(bad_pkg::RegRowScale, 13'(rs));
    write_register(bad_pkg::RegColScale, 13'(cs));
  endtask

  // Extremes of pixel values, sub-unity scales and out-of-range registers
  task automatic test_directed();
    set_geometry(4, 4, 2, 2, 512, 512);
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: send_pixel(8'hff, 8'h00, 8'haa);
        1: send_pixel(8'h00, 8'hff, 8'h55);
        2: send_pixel(8'hff, 8'hff, 8'hff);
        default: send_pixel(8'h00, 8'h00, 8'h00);
      endcase
    end
    // zero sizes clamp up, oversize dst width clamps down, scales below one
    set_geometry(3, 0, 2047, 0, 100, 100);
    repeat (3) send_pixel(8'hff, 8'h80, 8'h01);
    set_geometry(2, 2, 1, 1, 8191, 8191);
    send_random(4);
  endtask

  // Small random geometries, two frames each plus extra pixels past the end
  task automatic test_random_frames();
    int sw, sh;
    for (int i = 0; i < 11; i++) begin
      sw = $urandom_range(1, 8);
      sh = $urandom_range(1, 5);
      set_geometry(sw, sh, $urandom_range(1, sw + 1), $urandom_range(1, sh + 1),
                   ($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(256, 900),
                   ($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(256, 900));
      send_random(2 * sw * sh + $urandom_range(3));
    end
  endtask

  // Full-range dimensions and large scales, first blocks only
  task automatic test_extremes();
    set_geometry(4096, 1, 256, 1, 256, 4096);
    send_random(32);
    set_geometry(1024, 1, 1024, 1, 256, 256);
    send_random(16);
    set_geometry(1, 4096, 1, 256, 4096, 256);
    send_random(32);
  endtask

  // Receiver holds off while the sender keeps offering pixels
  task automatic test_backpressure();
    set_geometry(4, 4, 4, 4, 256, 256);
    quiet = 1'b1;
    hold_seq++;
    send_random(48);
    quiet = 1'b0;
  endtask

  initial begin
    errors = 0;
    mismatches = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_seq = 0;
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid = 1'b0;
    in_c0_i = '0;
    in_c1_i = '0;
    in_c2_i = '0;
    reg_src_w = 640;
    reg_src_h = 480;
    reg_dst_w = 320;
    reg_dst_h = 240;
    reg_row_scale = 512;
    reg_col_scale = 512;
    restart_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_frames();
    test_backpressure();
    test_extremes();

    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+hdl
hdl/bad_pkg.sv
hdl/bad_ram.sv
hdl/bad_div.sv
hdl/bad_front.sv
hdl/bad_back.sv
hdl/bad_fifo.sv
hdl/block_average_downscaler.sv
hdl/bad_checker.sv
test/block_average_downscaler_test.sv
